FILE: rtl/block_sparse_matvec_5x5_macros.svh
// Assertion macros shared by the block sparse matrix-vector multiply RTL.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef BLOCK_SPARSE_MATVEC_5X5_MACROS_SVH
`define BLOCK_SPARSE_MATVEC_5X5_MACROS_SVH

// same-cycle implication
`define BSMV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bsmv_pkg.sv
// Shared constants, types and the saturating adder of the block sparse matvec.
// No dependencies; used by every module of the block but bsmv_ram.
package bsmv_pkg;

	localparam int BS = 5;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;
	localparam int COL_W = 4;
	localparam int ROW_W = 3;
	localparam int BROW_W = 12;
	localparam int IN_DATA_W = 168;
	localparam int OUT_DATA_W = 336;
	localparam int OUT_PAD_W = OUT_DATA_W - BROW_W - BS * SUM_W;
	localparam int VECTOR_BLOCKS_DEF = 16;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_MUL = 1'b1;

	typedef logic [BS-1:0][VAL_W-1:0] vals_t;
	typedef logic [BS-1:0][SUM_W-1:0] sums_t;

	typedef struct packed {
		logic v;
		logic [ROW_W-1:0] row;
		logic emit;
		logic eom;
	} ctl_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
		if (s[SUM_W] != s[SUM_W-1]) begin
			sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sat_add = s[SUM_W-1:0];
		end
	endfunction

endpackage

FILE: rtl/block_sparse_matvec_5x5.sv
// A result leaves on m_tvalid after the multiply item that closes it passes s1, s2,
// s3..s7 and the output register. Throughput: one item per cycle unless s_tready drops:
// a multiply whose row matches one still in s1..s4 waits (row sum read-modify-write
// loop), and the pipe holds only while an emission waits for the output register.
// Reset: control, row sums and block row counter clear; the vector store is not cleared.
`include "block_sparse_matvec_5x5_macros.svh"

module block_sparse_matvec_5x5 #(
	parameter int VECTOR_BLOCKS = bsmv_pkg::VECTOR_BLOCKS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// block_column[3:0], row_in_block[6:4], end_of_matrix[7], val0..val4 [167:8]
	input  logic [bsmv_pkg::IN_DATA_W-1:0]       s_tdata,
	// action[0]
	input  logic [0:0]                           s_tuser,
	// last_in_block_row
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// block_row[11:0], out0..out4 [331:12], zero pad [335:332]
	output logic [bsmv_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int AW = (VECTOR_BLOCKS > 1) ? $clog2(VECTOR_BLOCKS) : 1;
	localparam int SLICE_W = bsmv_pkg::BS * bsmv_pkg::VAL_W;

	logic [bsmv_pkg::COL_W-1:0] col;
	logic [bsmv_pkg::ROW_W-1:0] row;
	logic eom;
	bsmv_pkg::vals_t vals;
	logic is_mul, row_ok, col_ok, hazard, s_fire, adv;
	logic [AW+bsmv_pkg::COL_W-1:0] col_ext;
	logic ram_we, ram_re;
	logic [SLICE_W-1:0] ram_rdata;
	bsmv_pkg::ctl_t ctl_s1, ctl_s2;
	bsmv_pkg::ctl_t [1:0] busy;
	logic col_ok_s1;
	bsmv_pkg::vals_t vals_s1;
	bsmv_pkg::sums_t prod_s2;

	assign col = s_tdata[3:0];
	assign row = s_tdata[6:4];
	assign eom = s_tdata[7];
	assign vals = s_tdata[bsmv_pkg::IN_DATA_W-1:8];
	assign col_ext = {{AW{1'b0}}, col};

	assign is_mul = s_tuser[0] == bsmv_pkg::ACT_MUL;
	assign row_ok = row < bsmv_pkg::ROW_W'(bsmv_pkg::BS);
	assign col_ok = 32'(col) < 32'(VECTOR_BLOCKS);

	// hold a multiply back while its row is still being summed ahead of it
	assign hazard = is_mul && row_ok &&
		((ctl_s1.v && ctl_s1.row == row) || (ctl_s2.v && ctl_s2.row == row) ||
		(busy[0].v && busy[0].row == row) || (busy[1].v && busy[1].row == row));

	assign s_tready = adv && !hazard;
	assign s_fire = s_tvalid && s_tready;

	assign ram_we = s_fire && !is_mul && col_ok;
	assign ram_re = s_fire && is_mul && row_ok && col_ok;

	bsmv_ram #(
		.WIDTH(SLICE_W),
		.DEPTH(VECTOR_BLOCKS)
	) u_vec_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(col_ext[AW-1:0]),
		.wdata(vals),
		.re(ram_re),
		.raddr(col_ext[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1.v <= s_fire && is_mul && row_ok;
			ctl_s1.row <= row;
			ctl_s1.emit <= s_tlast && row == bsmv_pkg::ROW_W'(bsmv_pkg::BS - 1);
			ctl_s1.eom <= eom;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_ok_s1 <= col_ok;
			vals_s1 <= vals;
		end
	end

	bsmv_mul u_mul (
		.clk(clk),
		.en(adv),
		.col_ok(col_ok_s1),
		.a(vals_s1),
		.x(ram_rdata),
		.prod_s2(prod_s2)
	);

	bsmv_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_s2(ctl_s2),
		.prod_s2(prod_s2),
		.adv(adv),
		.busy(busy),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	`BSMV_ASSERT_NOW(a_row_spacing, ctl_s1.v, !((ctl_s2.v && ctl_s2.row == ctl_s1.row) || (busy[0].v && busy[0].row == ctl_s1.row) || (busy[1].v && busy[1].row == ctl_s1.row)), "same row too close behind in the accumulate loop")

endmodule

FILE: rtl/bsmv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bsmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/bsmv_mul.sv
// Product stage: five signed 32x32 multiplies of a matrix row by a vector slice.
// Depends on bsmv_pkg.
module bsmv_mul (
	input  logic            clk,
	input  logic            en,
	input  logic            col_ok,
	input  bsmv_pkg::vals_t a,
	input  bsmv_pkg::vals_t x,
	output bsmv_pkg::sums_t prod_s2
);

	logic signed [bsmv_pkg::SUM_W-1:0] p [bsmv_pkg::BS];

	for (genvar i = 0; i < bsmv_pkg::BS; i++) begin : g_mul
		assign p[i] = $signed(a[i]) * $signed(x[i]);
	end

	// a slice outside the store counts as zero, so its products are forced to zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < bsmv_pkg::BS; i++) begin
				prod_s2[i] <= col_ok ? p[i] : '0;
			end
		end
	end

endmodule

FILE: rtl/bsmv_acc.sv
// Accumulate pipeline: five saturating add stages, row sums, output register.
// Depends on bsmv_pkg and the assertion macros header.
`include "block_sparse_matvec_5x5_macros.svh"

module bsmv_acc (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bsmv_pkg::ctl_t                       ctl_s2,
	input  bsmv_pkg::sums_t                      prod_s2,
	output logic                                 adv,
	output bsmv_pkg::ctl_t [1:0]                 busy,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bsmv_pkg::OUT_DATA_W-1:0]      m_tdata
);

	typedef struct packed {
		bsmv_pkg::ctl_t ctl;
		logic [bsmv_pkg::SUM_W-1:0] acc;
		bsmv_pkg::sums_t prod;
	} stage_t;

	stage_t st_s3, st_s4, st_s5, st_s6, st_s7;
	bsmv_pkg::sums_t sum_q;
	bsmv_pkg::sums_t out_sum_q;
	logic [bsmv_pkg::BROW_W-1:0] out_brow_q;
	logic [bsmv_pkg::BROW_W-1:0] row_cnt_q;
	logic out_valid_q;
	logic emit_ahead;
	logic fire_s7;
	logic emit_s7;
	logic [bsmv_pkg::SUM_W-1:0] base;

	assign emit_s7 = st_s7.ctl.v && st_s7.ctl.emit;
	// hold the whole pipe only while an emission waits for the output register
	assign adv = !(emit_s7 && out_valid_q && !m_tready);
	assign fire_s7 = adv && st_s7.ctl.v;
	assign busy = {st_s4.ctl, st_s3.ctl};

	assign emit_ahead = (st_s3.ctl.v && st_s3.ctl.emit) || (st_s4.ctl.v && st_s4.ctl.emit) ||
		(st_s5.ctl.v && st_s5.ctl.emit) || (st_s6.ctl.v && st_s6.ctl.emit) || emit_s7;

	// an emission still in flight will clear the sums; otherwise forward the
	// value leaving the last stage ahead of the register write
	always_comb begin
		if (emit_ahead) begin
			base = '0;
		end else if (st_s7.ctl.v && st_s7.ctl.row == ctl_s2.row) begin
			base = st_s7.acc;
		end else begin
			base = sum_q[ctl_s2.row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s3 <= '0;
			st_s4 <= '0;
			st_s5 <= '0;
			st_s6 <= '0;
			st_s7 <= '0;
		end else if (adv) begin
			st_s3.ctl <= ctl_s2;
			st_s3.prod <= prod_s2;
			st_s3.acc <= bsmv_pkg::sat_add(base, prod_s2[0]);
			st_s4.ctl <= st_s3.ctl;
			st_s4.prod <= st_s3.prod;
			st_s4.acc <= bsmv_pkg::sat_add(st_s3.acc, st_s3.prod[1]);
			st_s5.ctl <= st_s4.ctl;
			st_s5.prod <= st_s4.prod;
			st_s5.acc <= bsmv_pkg::sat_add(st_s4.acc, st_s4.prod[2]);
			st_s6.ctl <= st_s5.ctl;
			st_s6.prod <= st_s5.prod;
			st_s6.acc <= bsmv_pkg::sat_add(st_s5.acc, st_s5.prod[3]);
			st_s7.ctl <= st_s6.ctl;
			st_s7.prod <= st_s6.prod;
			st_s7.acc <= bsmv_pkg::sat_add(st_s6.acc, st_s6.prod[4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			row_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s7) begin
				if (st_s7.ctl.emit) begin
					sum_q <= '0;
					row_cnt_q <= st_s7.ctl.eom ? '0 : row_cnt_q + 1'b1;
				end else begin
					sum_q[st_s7.ctl.row] <= st_s7.acc;
				end
			end
			if (fire_s7 && st_s7.ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s7 && st_s7.ctl.emit) begin
			out_brow_q <= row_cnt_q;
			for (int i = 0; i < bsmv_pkg::BS; i++) begin
				out_sum_q[i] <= (st_s7.ctl.row == bsmv_pkg::ROW_W'(i)) ? st_s7.acc : sum_q[i];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{bsmv_pkg::OUT_PAD_W{1'b0}}, out_sum_q, out_brow_q};

	`BSMV_ASSERT_NOW(a_plain_never_holds, st_s7.ctl.v && !st_s7.ctl.emit, adv, "non-emitting item stalled the pipeline")
	`BSMV_ASSERT_NEXT(a_emit_clears, fire_s7 && st_s7.ctl.emit, sum_q == '0, "row sums not cleared after emission")
	`BSMV_ASSERT_NEXT(a_row_count, fire_s7 && st_s7.ctl.emit, row_cnt_q == ($past(st_s7.ctl.eom) ? '0 : bsmv_pkg::BROW_W'($past(row_cnt_q) + 1'b1)), "block row counter stepped wrongly")

endmodule

FILE: test/bsmv_checker.sv
// Checker for block_sparse_matvec_5x5: watches both stream channels, predicts each
// finished block row and compares it field by field. Depends on bsmv_pkg only.
module bsmv_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// block_column, row_in_block, end_of_matrix, val0..val4
	input  logic [bsmv_pkg::IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [0:0]                      s_tuser,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// block_row, out0..out4, zero pad
	input  logic [bsmv_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              mismatches,
	output int                              sums_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import bsmv_pkg::*;

	localparam int SLICES = VECTOR_BLOCKS_DEF;
	localparam int EOM_BIT = COL_W + ROW_W;
	localparam int VAL_LSB = COL_W + ROW_W + 1;

	typedef struct packed {
		logic [BROW_W-1:0] brow;
		sums_t             sums;
	} brow_sums_t;

	brow_sums_t              sums_due[$];
	logic [VAL_W-1:0]        slice_mem [SLICES][BS];
	logic signed [SUM_W-1:0] row_acc [BS];
	logic [BROW_W-1:0]       brow_next;
	int                      fail_n = 0;

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b);
		logic signed [SUM_W-1:0] r;
		r = a + b;
		// operands of one sign giving a wrapped sum of the other sign: clamp
		if (a[SUM_W-1] == b[SUM_W-1] && r[SUM_W-1] != a[SUM_W-1]) begin
			r = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [SUM_W-1:0] want,
		input logic [SUM_W-1:0] got);
		fail_n++;
		if (fail_n <= 10) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic take_item();
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] x;
		logic signed [SUM_W-1:0] prod;
		logic signed [SUM_W-1:0] acc;
		brow_sums_t              res;
		int                      i;
		col = s_tdata[COL_W-1:0];
		row = s_tdata[COL_W +: ROW_W];
		if (s_tuser[0] == ACT_LOAD) begin
			if (col < SLICES) begin
				for (i = 0; i < BS; i++) begin
					slice_mem[col][i] = s_tdata[VAL_LSB + VAL_W*i +: VAL_W];
				end
			end
			return;
		end
		// rows past the block are dropped whole
		if (row >= BS) return;
		if (col < SLICES) begin
			acc = row_acc[row];
			for (i = 0; i < BS; i++) begin
				a = s_tdata[VAL_LSB + VAL_W*i +: VAL_W];
				x = slice_mem[col][i];
				prod = a * x;
				acc = sat_sum(acc, prod);
			end
			row_acc[row] = acc;
		end
		if (!(s_tlast && row == BS - 1)) return;
		res.brow = brow_next;
		for (i = 0; i < BS; i++) begin
			res.sums[i] = row_acc[i];
			row_acc[i] = '0;
		end
		sums_due.push_back(res);
		brow_next = s_tdata[EOM_BIT] ? '0 : brow_next + 1'b1;
	endtask

	task automatic check_result();
		brow_sums_t want;
		int         i;
		if (sums_due.size() == 0) begin
			note_mismatch("unexpected result, block row", '0, m_tdata[BROW_W-1:0]);
			return;
		end
		want = sums_due.pop_front();
		if (m_tdata[BROW_W-1:0] !== want.brow) begin
			note_mismatch("block row", want.brow, m_tdata[BROW_W-1:0]);
		end
		for (i = 0; i < BS; i++) begin
			if (m_tdata[BROW_W + SUM_W*i +: SUM_W] !== want.sums[i]) begin
				note_mismatch($sformatf("out%0d", i), want.sums[i],
					m_tdata[BROW_W + SUM_W*i +: SUM_W]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_due.delete();
			foreach (row_acc[i]) row_acc[i] = '0;
			brow_next = '0;
		end else begin
			if (m_tvalid && m_tready) check_result();
			if (s_tvalid && s_tready) take_item();
		end
		mismatches <= fail_n;
		sums_pending <= sums_due.size();
	end

endmodule

FILE: test/testbench.sv
// Top of the block_sparse_matvec_5x5 testbench: clock, reset, stream stimulus and
// output back-pressure, with bsmv_checker beside the block. Depends on bsmv_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bsmv_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    mismatches;
	int                    sums_pending;

	int                           gap_pct = 0;
	int                           stall_pct = 0;
	int                           hold_reqs = 0;
	logic [VECTOR_BLOCKS_DEF-1:0] loaded = '0;

	always #2 clk = ~clk;

	block_sparse_matvec_5x5 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bsmv_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.sums_pending (sums_pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [VAL_W-1:0] rand_val();
		logic [VAL_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return {{13{r[18]}}, r[18:0]};
			6, 7:             return r;
			8: begin
				case (r[2:0])
					0:       return 32'h7fff_ffff;
					1:       return 32'h8000_0000;
					2:       return 32'hffff_ffff;
					3:       return 32'h0001_0000;
					default: return 32'h0000_0001;
				endcase
			end
			default:          return '0;
		endcase
	endfunction

	function automatic vals_t rand_vals();
		vals_t v;
		foreach (v[i]) v[i] = rand_val();
		return v;
	endfunction

	// multiplies only ever read slices that have been loaded
	function automatic int loaded_col();
		int c;
		do c = $urandom_range(0, VECTOR_BLOCKS_DEF - 1); while (!loaded[c]);
		return c;
	endfunction

	task automatic offer(input logic act, input logic [COL_W-1:0] col,
		input logic [ROW_W-1:0] row, input logic last, input logic eom, input vals_t v);
		s_tdata <= {v, eom, row, col};
		s_tuser <= act;
		s_tlast <= last;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_LOAD) loaded[col] = 1'b1;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	task automatic load_slice(input int col);
		offer(ACT_LOAD, COL_W'(col), ROW_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), rand_vals());
	endtask

	// one well-formed block row; row 4 of the last block closes it
	task automatic send_block_row(input int nblk, input logic eom);
		int   ord [BS];
		int   b, r, j, t, col;
		logic closing;
		for (b = 0; b < nblk; b++) begin
			col = loaded_col();
			for (r = 0; r < BS; r++) ord[r] = r;
			for (r = BS - 1; r > 0; r--) begin
				j = $urandom_range(0, r);
				t = ord[r];
				ord[r] = ord[j];
				ord[j] = t;
			end
			if (b == nblk - 1) begin
				for (r = 0; r < BS; r++) begin
					if (ord[r] == BS - 1) begin
						ord[r] = ord[BS - 1];
						ord[BS - 1] = BS - 1;
					end
				end
			end
			for (r = 0; r < BS; r++) begin
				closing = (b == nblk - 1) && (r == BS - 1);
				offer(ACT_MUL, COL_W'(col), ROW_W'(ord[r]), b == nblk - 1,
					closing ? eom : 1'($urandom_range(0, 1)), rand_vals());
			end
			if (b < nblk - 1 && $urandom_range(0, 5) == 0) load_slice(loaded_col());
		end
	endtask

	// hold the input until every result is out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (sums_pending == 0);
		@(posedge clk);
	endtask

	task automatic run_phase(input int n, input int sgap, input int rstall);
		int done;
		int nblk;
		int pick;
		done = 0;
		gap_pct = sgap;
		stall_pct = rstall;
		while (done < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				nblk = $urandom_range(1, 3);
				send_block_row(nblk, $urandom_range(0, 7) == 0);
				done += BS * nblk;
			end else if (pick < 88) begin
				load_slice($urandom_range(0, VECTOR_BLOCKS_DEF - 1));
				done++;
			end else if (pick < 94) begin
				// row past the block: dropped, not counted
				offer(ACT_MUL, COL_W'(loaded_col()), ROW_W'($urandom_range(BS, 7)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_vals());
			end else begin
				offer(ACT_MUL, COL_W'(loaded_col()), ROW_W'($urandom_range(0, BS - 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_vals());
				done++;
			end
		end
		drain();
	endtask

	initial begin : sink
		int gap_left;
		int hold_seen;
		gap_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				gap_left = 400;
			end else if (gap_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				gap_left = idle_len();
			end
			if (gap_left > 0) begin
				m_tready <= 1'b0;
				gap_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		vals_t v_neg;
		vals_t v_pos;
		vals_t v_unit;
		vals_t v_zero;
		int    c;
		foreach (v_neg[i]) begin
			v_neg[i] = 32'h8000_0000;
			v_pos[i] = 32'h7fff_ffff;
			v_zero[i] = '0;
		end
		v_unit = {32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'hffff_0000, 32'h0001_0000};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		stall_pct = 20;
		// control fields on a load must be ignored
		offer(ACT_LOAD, 4'd0, 3'd7, 1'b1, 1'b1, v_neg);
		offer(ACT_LOAD, 4'd15, 3'd5, 1'b0, 1'b0, v_pos);
		offer(ACT_LOAD, 4'd3, 3'd0, 1'b1, 1'b0, v_unit);
		// saturate both ways, then keep adding across a second block
		offer(ACT_MUL, 4'd0, 3'd0, 1'b0, 1'b0, v_neg);
		offer(ACT_MUL, 4'd0, 3'd1, 1'b0, 1'b0, v_pos);
		offer(ACT_MUL, 4'd0, 3'd2, 1'b0, 1'b0, v_zero);
		offer(ACT_MUL, 4'd0, 3'd3, 1'b0, 1'b1, rand_vals());
		offer(ACT_MUL, 4'd0, 3'd4, 1'b0, 1'b1, v_neg);
		offer(ACT_MUL, 4'd3, 3'd7, 1'b1, 1'b1, v_pos);
		offer(ACT_MUL, 4'd3, 3'd5, 1'b1, 1'b0, v_neg);
		offer(ACT_MUL, 4'd15, 3'd0, 1'b1, 1'b0, v_neg);
		offer(ACT_MUL, 4'd15, 3'd1, 1'b1, 1'b0, v_neg);
		offer(ACT_MUL, 4'd15, 3'd2, 1'b1, 1'b0, v_pos);
		offer(ACT_MUL, 4'd15, 3'd3, 1'b1, 1'b1, rand_vals());
		offer(ACT_MUL, 4'd15, 3'd4, 1'b1, 1'b0, rand_vals());
		// empty block row sent as one zero block, ending the matrix
		for (c = 0; c < BS; c++) offer(ACT_MUL, 4'd3, ROW_W'(c), 1'b1, 1'b1, v_zero);
		offer(ACT_MUL, 4'd3, 3'd4, 1'b1, 1'b0, v_unit);
		offer(ACT_MUL, 4'd3, 3'd6, 1'b0, 1'b0, v_pos);
		offer(ACT_MUL, 4'd3, 3'd2, 1'b1, 1'b0, rand_vals());
		offer(ACT_MUL, 4'd3, 3'd4, 1'b1, 1'b1, rand_vals());
		drain();

		for (c = 0; c < VECTOR_BLOCKS_DEF; c++) load_slice(c);
		run_phase(250, 0, 0);
		run_phase(250, 30, 30);
		// long output hold while items keep coming
		hold_reqs++;
		run_phase(250, 0, 10);
		run_phase(250, 10, 50);

		// a string of one-row block rows, each closing at once
		gap_pct = 0;
		stall_pct = 0;
		repeat (60) offer(ACT_MUL, COL_W'(loaded_col()), 3'd4, 1'b1, 1'b0, rand_vals());
		gap_pct = 10;
		stall_pct = 10;
		send_block_row(2, 1'b1);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
